### design/sasfp_pkg.sv
`default_nettype none

package sasfp_pkg;

    // link byte codes
    localparam logic [7:0] LeadData = 8'h96;
    localparam logic [7:0] AckLow   = 8'hAC;
    localparam logic [7:0] AckHigh  = 8'hAF;
    localparam logic [7:0] EndByte  = 8'h8D;

    // frame positions after the lead byte
    localparam logic [3:0] PosSumHigh = 4'd13;
    localparam logic [3:0] PosSumLow  = 4'd14;
    localparam logic [3:0] PosEnd     = 4'd15;

    localparam int NumAxes = 6;
    localparam int QDepth  = 2;
    localparam int QCntW   = $clog2(QDepth + 1);
    localparam int QPtrW   = $clog2(QDepth);

    // commands handed from the classifier to the execution side
    typedef enum logic [2:0] {
        CMD_START_DATA = 3'd0,
        CMD_START_ACK  = 3'd1,
        CMD_AXIS_HIGH  = 3'd2,
        CMD_AXIS_LOW   = 3'd3,
        CMD_SUM_HIGH   = 3'd4,
        CMD_SUM_LOW    = 3'd5,
        CMD_END_DATA   = 3'd6,
        CMD_END_ACK    = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_END_BYTE = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd       cmd;
        logic [2:0] idx;
        logic [7:0] data;
    } t_entry;

    typedef struct packed {
        logic                      kind;
        logic [7:0]                ack_code;
        logic [NumAxes-1:0][13:0]  axis;
        t_status                   status;
    } t_result;

endpackage

`default_nettype wire

### design/sasfp_front.sv
`default_nettype none

module sasfp_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire  [7:0]          i_byte,
    input  wire                 i_q_full,
    output logic                o_ready,
    output logic                o_push,
    output sasfp_pkg::t_entry   o_entry
);

    logic [3:0] r_pos, n_pos;
    logic       r_kind, n_kind;
    logic       accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // classify each byte by its place in the response
    always_comb begin
        n_pos         = r_pos;
        n_kind        = r_kind;
        o_push        = 1'b0;
        o_entry.cmd   = sasfp_pkg::CMD_START_DATA;
        o_entry.idx   = 3'd0;
        o_entry.data  = i_byte;
        if (accept) begin
            if (r_pos == 4'd0) begin
                if (i_byte == sasfp_pkg::LeadData) begin
                    o_push      = 1'b1;
                    o_entry.cmd = sasfp_pkg::CMD_START_DATA;
                    n_pos       = 4'd1;
                    n_kind      = 1'b1;
                end else if (i_byte >= sasfp_pkg::AckLow && i_byte <= sasfp_pkg::AckHigh) begin
                    o_push      = 1'b1;
                    o_entry.cmd = sasfp_pkg::CMD_START_ACK;
                    n_pos       = 4'd1;
                    n_kind      = 1'b0;
                end
            end else if (!r_kind) begin
                o_push      = 1'b1;
                o_entry.cmd = sasfp_pkg::CMD_END_ACK;
                n_pos       = 4'd0;
            end else begin
                o_push = 1'b1;
                n_pos  = r_pos + 4'd1;
                priority if (r_pos == sasfp_pkg::PosEnd) begin
                    o_entry.cmd = sasfp_pkg::CMD_END_DATA;
                    n_pos       = 4'd0;
                end else if (r_pos == sasfp_pkg::PosSumLow) begin
                    o_entry.cmd = sasfp_pkg::CMD_SUM_LOW;
                end else if (r_pos == sasfp_pkg::PosSumHigh) begin
                    o_entry.cmd = sasfp_pkg::CMD_SUM_HIGH;
                end else if (r_pos[0]) begin
                    o_entry.cmd = sasfp_pkg::CMD_AXIS_HIGH;
                end else begin
                    o_entry.cmd = sasfp_pkg::CMD_AXIS_LOW;
                    o_entry.idx = r_pos[3:1] - 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 4'd0;
            r_kind <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_kind <= n_kind;
        end
    end

endmodule

`default_nettype wire

### design/sasfp_queue.sv
`default_nettype none

module sasfp_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire sasfp_pkg::t_entry i_entry,
    input  wire                 i_pop,
    output logic                o_full,
    output logic                o_valid,
    output sasfp_pkg::t_entry   o_entry
);

    sasfp_pkg::t_entry                 r_mem [sasfp_pkg::QDepth];
    logic [sasfp_pkg::QPtrW-1:0]       r_wptr, r_rptr;
    logic [sasfp_pkg::QCntW-1:0]       r_count;

    assign o_full  = (r_count == sasfp_pkg::QCntW'(sasfp_pkg::QDepth));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sasfp_pkg::QCntW'(sasfp_pkg::QDepth))
        else $error("queue count above depth");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not grow on push");

endmodule

`default_nettype wire

### design/sasfp_back.sv
`default_nettype none

module sasfp_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire sasfp_pkg::t_entry i_entry,
    output logic                o_pop,
    output logic                o_res_valid,
    input  wire                 i_res_ready,
    output sasfp_pkg::t_result  o_result
);

    logic [13:0]                       r_sum, n_sum;
    logic [6:0]                        r_high, n_high;
    logic [13:0]                       r_rsum, n_rsum;
    logic [7:0]                        r_ack, n_ack;
    logic [sasfp_pkg::NumAxes-1:0][13:0] r_axis;
    logic                              r_out_valid, n_out_valid;
    sasfp_pkg::t_result                r_res, n_res;
    logic                              is_end;
    logic [13:0]                       byte_ext;

    assign byte_ext = {6'b0, i_entry.data};
    assign is_end   = (i_entry.cmd == sasfp_pkg::CMD_END_DATA) ||
                      (i_entry.cmd == sasfp_pkg::CMD_END_ACK);
    // only a finishing command waits for the output register
    assign o_pop    = i_valid && (!is_end || !r_out_valid || i_res_ready);

    // execute one command
    always_comb begin
        n_sum       = r_sum;
        n_high      = r_high;
        n_rsum      = r_rsum;
        n_ack       = r_ack;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_res_ready;
        if (o_pop) begin
            unique case (i_entry.cmd)
                sasfp_pkg::CMD_START_DATA: n_sum = byte_ext;
                sasfp_pkg::CMD_START_ACK:  n_ack = i_entry.data;
                sasfp_pkg::CMD_AXIS_HIGH: begin
                    n_sum  = r_sum + byte_ext;
                    n_high = i_entry.data[6:0];
                end
                sasfp_pkg::CMD_AXIS_LOW:   n_sum = r_sum + byte_ext;
                sasfp_pkg::CMD_SUM_HIGH:   n_high = i_entry.data[6:0];
                sasfp_pkg::CMD_SUM_LOW:    n_rsum = {r_high, i_entry.data[6:0]};
                sasfp_pkg::CMD_END_DATA: begin
                    n_out_valid    = 1'b1;
                    n_res.kind     = 1'b1;
                    n_res.ack_code = 8'd0;
                    n_res.axis     = r_axis;
                    if (i_entry.data != sasfp_pkg::EndByte) begin
                        n_res.status = sasfp_pkg::ST_END_BYTE;
                    end else if (r_rsum != r_sum) begin
                        n_res.status = sasfp_pkg::ST_CHECKSUM;
                    end else begin
                        n_res.status = sasfp_pkg::ST_OK;
                    end
                end
                sasfp_pkg::CMD_END_ACK: begin
                    n_out_valid    = 1'b1;
                    n_res.kind     = 1'b0;
                    n_res.ack_code = r_ack;
                    n_res.axis     = '0;
                    n_res.status   = (i_entry.data == sasfp_pkg::EndByte) ?
                                     sasfp_pkg::ST_OK : sasfp_pkg::ST_END_BYTE;
                end
                default: ;
            endcase
        end
    end

    // axis store, written on each low byte
    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.cmd == sasfp_pkg::CMD_AXIS_LOW) begin
            r_axis[i_entry.idx] <= {r_high, i_entry.data[6:0]};
        end
    end

    // working registers and output register
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_high      <= '0;
            r_rsum      <= '0;
            r_ack       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_high      <= n_high;
            r_rsum      <= n_rsum;
            r_ack       <= n_ack;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_result    = r_res;

endmodule

`default_nettype wire

### design/six_axis_sensor_frame_parser_core.sv
// Six-axis sensor link frame parser.
// Input stream: one received link byte per transfer on the s-side
// (i_s_tdata). A 0x96 lead byte opens a 16-byte data frame, a lead byte
// 0xAC..0xAF opens a two-byte acknowledgement, other idle bytes are dropped.
// Output stream: one transfer per finished response; o_m_tuser is the kind
// (1 data frame, 0 acknowledgement), o_m_tdata carries the echoed command,
// the six 14-bit axis values and the status (ok, checksum, end byte).
// A classifier tags each byte with a command and writes it to a two-entry
// queue; an execution side drains one command a cycle into the sum, axis
// and result registers unless a finishing command waits for a stalled
// receiver. One byte per cycle is sustained while results are taken.
// o_m_tvalid rises once the last byte has passed through the queue and the
// output register. When the receiver stalls, the result holds in the output
// register, the execution side stops only at the next finishing command, and
// the queue fills and drops o_s_tready.
// Reset (synchronous, active low) returns the parser to idle and empties
// the queue and output register.
`default_nettype none

module six_axis_sensor_frame_parser_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // rx_byte
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [95:0] o_m_tdata,   // ack_code, axis_x, axis_y, axis_z, axis_a,
                                     // axis_b, axis_c, status, zero pad
    output logic        o_m_tuser    // kind
);

    logic               q_push, q_pop, q_full, q_valid;
    sasfp_pkg::t_entry  push_entry, pop_entry;
    sasfp_pkg::t_result result;

    sasfp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_byte   (i_s_tdata),
        .i_q_full (q_full),
        .o_ready  (o_s_tready),
        .o_push   (q_push),
        .o_entry  (push_entry)
    );

    sasfp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_entry  (push_entry),
        .i_pop    (q_pop),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_entry  (pop_entry)
    );

    sasfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_entry     (pop_entry),
        .o_pop       (q_pop),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_result    (result)
    );

    // pack the result fields, lowest first
    assign o_m_tuser = result.kind;
    assign o_m_tdata = {2'b00, result.status,
                        result.axis[5], result.axis[4], result.axis[3],
                        result.axis[2], result.axis[1], result.axis[0],
                        result.ack_code};

endmodule

`default_nettype wire

### test/tb_six_axis_sensor_frame_parser_core.sv
`default_nettype none

module tb_six_axis_sensor_frame_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    // one finished response as seen on the master side
    typedef struct packed {
        logic                 kind;
        logic [7:0]           ack_code;
        logic [5:0][13:0]     axis;
        sasfp_pkg::t_status   status;
    } t_response;

    localparam int RandomBytes = 1300;
    localparam int QuietLo     = 500;
    localparam int QuietHi     = 800;
    localparam int MaxReports  = 10;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic        m_tuser;

    // bytes waiting to go out on the link, and responses the parser owes us
    logic [7:0]  link_bytes[$];
    t_response   owed_responses[$];

    int unsigned bytes_taken = 0;
    int unsigned mismatches  = 0;

    // shadow parser state
    logic [4:0]       pos;
    logic             in_data;
    logic [7:0]       held_code;
    logic [13:0]      sum_acc;
    logic [6:0]       hi7;
    logic [5:0][13:0] axis_mem;
    logic [13:0]      sum_rx;

    six_axis_sensor_frame_parser_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),     // rx_byte
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),     // ack_code, axis_x..axis_c, status, zero pad
        .o_m_tuser  (m_tuser)      // kind
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic bit quiet_stretch();
        return bytes_taken >= QuietLo && bytes_taken < QuietHi;
    endfunction

    task automatic parser_idle();
        pos       = '0;
        in_data   = 1'b0;
        held_code = '0;
        sum_acc   = '0;
        hi7       = '0;
        sum_rx    = '0;
    endtask

    // advance the shadow parser by one link byte
    task automatic parse_link_byte(input logic [7:0] b);
        t_response r;
        r = '0;
        if (pos == 0) begin
            if (b == sasfp_pkg::LeadData) begin
                in_data   = 1'b1;
                held_code = '0;
                sum_acc   = 14'(b);
                pos       = 5'd1;
            end else if (b >= sasfp_pkg::AckLow && b <= sasfp_pkg::AckHigh) begin
                in_data   = 1'b0;
                held_code = b;
                pos       = 5'd1;
            end
        end else if (!in_data) begin
            r.kind     = 1'b0;
            r.ack_code = held_code;
            r.status   = (b == sasfp_pkg::EndByte) ? sasfp_pkg::ST_OK
                                                   : sasfp_pkg::ST_END_BYTE;
            owed_responses.push_back(r);
            parser_idle();
        end else if (pos <= 12) begin
            sum_acc = sum_acc + 14'(b);
            if (pos[0])
                hi7 = b[6:0];
            else
                axis_mem[(pos - 2) >> 1] = {hi7, b[6:0]};
            pos = pos + 5'd1;
        end else if (pos == 13) begin
            hi7 = b[6:0];
            pos = 5'd14;
        end else if (pos == 14) begin
            sum_rx = {hi7, b[6:0]};
            pos    = 5'd15;
        end else begin
            // end of data frame, end byte checked before checksum
            r.kind = 1'b1;
            r.axis = axis_mem;
            if (b != sasfp_pkg::EndByte)
                r.status = sasfp_pkg::ST_END_BYTE;
            else if (sum_rx != sum_acc)
                r.status = sasfp_pkg::ST_CHECKSUM;
            else
                r.status = sasfp_pkg::ST_OK;
            owed_responses.push_back(r);
            parser_idle();
        end
    endtask

    // queue a full data frame; checksum bytes may carry a stray msb
    task automatic queue_data_frame(input logic [11:0][7:0] payload, input bit sum_good,
                                    input bit end_good, input bit sum_msb);
        logic [13:0] sum;
        sum = 14'(sasfp_pkg::LeadData);
        link_bytes.push_back(sasfp_pkg::LeadData);
        for (int k = 0; k < 12; k++) begin
            sum = sum + 14'(payload[k]);
            link_bytes.push_back(payload[k]);
        end
        if (!sum_good)
            sum = sum ^ 14'($urandom_range(1, 16383));
        link_bytes.push_back({sum_msb & $urandom_range(0, 1) == 1, sum[13:7]});
        link_bytes.push_back({sum_msb & $urandom_range(0, 1) == 1, sum[6:0]});
        link_bytes.push_back(end_good ? sasfp_pkg::EndByte : 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] payload_byte();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 8'($urandom_range(0, 127));
        else if (pick < 80)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'h7F;
            2: return 8'h80;
            default: return 8'hFF;
        endcase
    endfunction

    // stimulus
    initial begin
        logic [11:0][7:0] pl;
        int unsigned      queued;
        int unsigned      pick;
        logic [7:0]       end_b;

        // idle bytes that are dropped
        link_bytes.push_back(8'h00);
        link_bytes.push_back(8'hFF);
        link_bytes.push_back(sasfp_pkg::EndByte);
        // acknowledgements at both ends of the code range, one ending in a lead byte
        link_bytes.push_back(sasfp_pkg::AckLow);
        link_bytes.push_back(sasfp_pkg::EndByte);
        link_bytes.push_back(sasfp_pkg::AckHigh);
        link_bytes.push_back(sasfp_pkg::LeadData);
        // data frame with axis extremes and payload bytes with msb set
        pl = {8'h80, 8'h01, 8'hFF, 8'hFF, 8'h00, 8'h00,
              8'h7F, 8'h7F, 8'h00, 8'h80, 8'h7F, 8'hFF};
        queue_data_frame(pl, 1'b1, 1'b1, 1'b1);

        // random traffic: mostly well-formed responses, some noise and damage
        queued = 0;
        while (queued < RandomBytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                link_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 35) begin
                end_b = ($urandom_range(0, 99) < 80) ? sasfp_pkg::EndByte
                                                     : 8'($urandom_range(0, 255));
                link_bytes.push_back(8'($urandom_range(sasfp_pkg::AckLow,
                                                       sasfp_pkg::AckHigh)));
                link_bytes.push_back(end_b);
                queued += 2;
            end else begin
                for (int k = 0; k < 12; k++)
                    pl[k] = payload_byte();
                queue_data_frame(pl, $urandom_range(0, 99) < 70, $urandom_range(0, 99) < 85,
                                 $urandom_range(0, 99) < 30);
                queued += 16;
            end
        end
    end

    // reset and end of run
    initial begin
        parser_idle();
        axis_mem = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (link_bytes.size() != 0 || s_tvalid)
            @(posedge clk);
        while (owed_responses.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && owed_responses.size() == 0) begin
            $display("six_axis_sensor_frame_parser_core test passed");
        end else begin
            $display("six_axis_sensor_frame_parser_core test failed");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("six_axis_sensor_frame_parser_core test failed");
        $finish;
    end

    // slave-side driver
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_link_byte(s_tdata);
                bytes_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (link_bytes.size() != 0 &&
                    (quiet_stretch() || $urandom_range(0, 99) >= 35)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= link_bytes.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_response(input logic [95:0] d, input logic k);
        t_response got;
        t_response want;
        got.kind     = k;
        got.ack_code = d[7:0];
        for (int i = 0; i < 6; i++)
            got.axis[i] = d[8 + 14 * i +: 14];
        got.status = sasfp_pkg::t_status'(d[92 +: 2]);
        if (owed_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReports)
                $display("unexpected response kind %0d ack %h axes %h status %0d",
                         got.kind, got.ack_code, got.axis, got.status);
        end else begin
            want = owed_responses.pop_front();
            if (got != want) begin
                mismatches++;
                if (mismatches <= MaxReports) begin
                    $display("response mismatch: expected kind %0d ack %h axes %h status %0d",
                             want.kind, want.ack_code, want.axis, want.status);
                    $display("                      actual kind %0d ack %h axes %h status %0d",
                             got.kind, got.ack_code, got.axis, got.status);
                end
            end
        end
    endtask

    // master-side monitor with random back-pressure
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_response(m_tdata, m_tuser);
            m_tready <= quiet_stretch() || $urandom_range(0, 99) >= 35;
        end
    end

endmodule

`default_nettype wire

### files.f
design/sasfp_pkg.sv
design/sasfp_front.sv
design/sasfp_queue.sv
design/sasfp_back.sv
design/six_axis_sensor_frame_parser_core.sv
test/tb_six_axis_sensor_frame_parser_core.sv
